// File: hw/rtl/rect_list_coalescer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle list coalescer
// Immediate-implication and next-cycle forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RECT_LIST_COALESCER_UNIT_DEFINES_SVH
`define RECT_LIST_COALESCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define RLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle list coalescer package
// Shared rectangle, probe, entry and configuration types.
// ----------------------------------------------------------------------------
package rlc_pkg;
	localparam int MAX_RECTS = 64;
	localparam int CNT_W = $clog2(MAX_RECTS);

	typedef struct packed {
		logic [15:0]        height;
		logic [15:0]        width;
		logic signed [15:0] top;
		logic signed [15:0] left;
	} rect_t;

	typedef struct packed {
		logic  valid;
		rect_t rect;
	} entry_t;

	typedef struct packed {
		logic  valid;
		logic  done;
		rect_t rect;
	} probe_t;

	typedef struct packed {
		logic        vertical;
		logic [15:0] y_tol;
		logic [15:0] x_tol;
		logic [15:0] size_tol;
	} cfg_t;
endpackage

// File: hw/rtl/rlc_cell.sv
// ----------------------------------------------------------------------------
// Coalescer cell
// Holds one kept rectangle; fuses or stores a passing probe, or shifts.
// ----------------------------------------------------------------------------
module rlc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  rlc_pkg::cfg_t   cfg,
	input  rlc_pkg::probe_t probe_in,
	output rlc_pkg::probe_t probe_out,
	input  logic          shift_en,
	input  rlc_pkg::entry_t shift_in,
	output rlc_pkg::entry_t entry
);
	import rlc_pkg::*;

	localparam int W = 19;

	function automatic logic signed [W-1:0] sx(input logic [15:0] v);
		sx = signed'({{(W-16){v[15]}}, v});
	endfunction

	function automatic logic signed [W-1:0] zx(input logic [15:0] v);
		zx = signed'({{(W-16){1'b0}}, v});
	endfunction

	function automatic logic signed [W-1:0] absv(input logic signed [W-1:0] v);
		absv = v[W-1] ? -v : v;
	endfunction

	function automatic logic [15:0] sat16(input logic signed [W-1:0] v);
		sat16 = (v > zx(16'hFFFF)) ? 16'hFFFF : v[15:0];
	endfunction

	logic   entry_valid_q;
	rect_t  entry_rect_q;
	logic   probe_valid_q;
	logic   probe_done_q;
	rect_t  probe_rect_q;

	logic signed [W-1:0] al, at, aw, ah, kl, kt, kw, kh;
	logic signed [W-1:0] bot_a, bot_k, rt_a, rt_k;
	logic signed [W-1:0] lo_bot, lo_left, hi_top, hi_right;
	logic                pass_h, pass_v, match;
	rect_t               fused;

	always_comb begin
		al = sx(probe_in.rect.left);
		at = sx(probe_in.rect.top);
		aw = zx(probe_in.rect.width);
		ah = zx(probe_in.rect.height);
		kl = sx(entry_rect_q.left);
		kt = sx(entry_rect_q.top);
		kw = zx(entry_rect_q.width);
		kh = zx(entry_rect_q.height);
		bot_a = at - ah;
		bot_k = kt - kh;
		rt_a = al + aw;
		rt_k = kl + kw;
		pass_h = (kl <= rt_a + zx(cfg.x_tol)) && (al <= rt_k + zx(cfg.x_tol))
			&& ((cfg.size_tol == 16'd0) || (absv(ah - kh) <= zx(cfg.size_tol)))
			&& (absv(bot_a - bot_k) <= zx(cfg.y_tol));
		pass_v = (bot_a <= kt + zx(cfg.y_tol)) && (bot_k <= at + zx(cfg.y_tol))
			&& ((cfg.size_tol == 16'd0) || (absv(aw - kw) <= zx(cfg.size_tol)))
			&& (absv(al - kl) <= zx(cfg.x_tol));
		match = cfg.vertical ? pass_v : pass_h;
		lo_bot = (bot_a < bot_k) ? bot_a : bot_k;
		lo_left = (al < kl) ? al : kl;
		hi_top = (at > kt) ? at : kt;
		hi_right = (rt_a > rt_k) ? rt_a : rt_k;
		fused.left = lo_left[15:0];
		fused.top = hi_top[15:0];
		fused.width = sat16(hi_right - lo_left);
		fused.height = sat16(hi_top - lo_bot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
			probe_valid_q <= 1'b0;
		end else begin
			probe_valid_q <= probe_in.valid && !shift_en;
			if (shift_en) begin
				entry_valid_q <= shift_in.valid;
			end else if (probe_in.valid && !probe_in.done && !entry_valid_q) begin
				entry_valid_q <= 1'b1;
			end
		end
	end

	// A probe that is still open either fuses here, claims an empty slot, or moves on.
	always_ff @(posedge clk) begin
		probe_rect_q <= probe_in.rect;
		probe_done_q <= probe_in.done || !entry_valid_q || match;
		if (shift_en) begin
			entry_rect_q <= shift_in.rect;
		end else if (probe_in.valid && !probe_in.done) begin
			if (!entry_valid_q) begin
				entry_rect_q <= probe_in.rect;
			end else if (match) begin
				entry_rect_q <= fused;
			end
		end
	end

	assign entry = '{valid: entry_valid_q, rect: entry_rect_q};
	assign probe_out = '{valid: probe_valid_q, done: probe_done_q, rect: probe_rect_q};
endmodule

// File: hw/rtl/rlc_chain.sv
// ----------------------------------------------------------------------------
// Coalescer chain
// A row of cells that a probe walks one cell per cycle; shifts toward the head.
// ----------------------------------------------------------------------------
module rlc_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  rlc_pkg::cfg_t   cfg,
	input  rlc_pkg::probe_t probe,
	input  logic            shift_en,
	output rlc_pkg::entry_t head,
	output logic            second_valid
);
	import rlc_pkg::*;

	probe_t probe_w [MAX_RECTS+1];
	entry_t entry_w [MAX_RECTS];
	entry_t shift_w [MAX_RECTS];

	assign probe_w[0] = probe;

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		if (i == MAX_RECTS - 1) begin : g_tail
			assign shift_w[i] = '0;
		end else begin : g_mid
			assign shift_w[i] = entry_w[i+1];
		end
		rlc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.probe_in (probe_w[i]),
			.probe_out(probe_w[i+1]),
			.shift_en (shift_en),
			.shift_in (shift_w[i]),
			.entry    (entry_w[i])
		);
	end

	assign head = entry_w[0];
	assign second_valid = entry_w[1].valid;
endmodule

// File: hw/rtl/rect_list_coalescer_unit.sv
// ----------------------------------------------------------------------------
// Rectangle list coalescer
// Two-pass greedy merge of a rectangle list over two chains of cells.
// ----------------------------------------------------------------------------
// Each accepted rectangle walks the first chain of MAX_RECTS cells, one cell per
// cycle, and the block takes no new request until that walk is through. On
// the rectangle marked last, the first chain is shifted out entry by entry and
// each entry walks the second chain before the next one is shifted out; then
// the merged rectangles are streamed from the head of the second chain, one
// per cycle while taken.
module rect_list_coalescer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // rect_left, rect_top, rect_width, rect_height
	input  logic        s_axis_tlast,  // rect_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // out_left, out_top, out_width, out_height
	output logic        m_axis_tlast,  // out_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rlc_pkg::*;
	`include "rect_list_coalescer_unit_defines.svh"

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_YTOL = 2'd1;
	localparam logic [1:0] REG_XTOL = 2'd2;
	localparam logic [1:0] REG_STOL = 2'd3;

	typedef enum logic [2:0] {S_IDLE, S_PASS1, S_LAUNCH, S_PASS2, S_EMIT} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_q;
	logic               probe1_valid_q, probe2_valid_q;
	rect_t              probe1_rect_q, probe2_rect_q;
	probe_t             probe1, probe2;
	logic               mode_q;
	logic [15:0]        ytol_q, xtol_q, stol_q;
	cfg_t               cfg1, cfg2;
	entry_t             head1, head2;
	logic               second1, second2;
	logic               shift1, shift2;
	logic               s_fire, m_fire;

	assign pready = 1'b1;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			ytol_q <= 16'd16;
			xtol_q <= 16'd32;
			stol_q <= 16'd16;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MODE: mode_q <= pwdata[0];
				REG_YTOL: ytol_q <= pwdata[15:0];
				REG_XTOL: xtol_q <= pwdata[15:0];
				REG_STOL: stol_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE: prdata = {31'd0, mode_q};
			REG_YTOL: prdata = {16'd0, ytol_q};
			REG_XTOL: prdata = {16'd0, xtol_q};
			REG_STOL: prdata = {16'd0, stol_q};
		endcase
	end

	assign cfg1 = '{vertical: !mode_q, y_tol: ytol_q, x_tol: xtol_q, size_tol: stol_q};
	assign cfg2 = '{vertical: mode_q, y_tol: ytol_q, x_tol: xtol_q, size_tol: stol_q};

	assign s_axis_tready = (state_q == S_IDLE);
	assign shift1 = (state_q == S_LAUNCH) && head1.valid;
	assign shift2 = m_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			last_q <= 1'b0;
			probe1_valid_q <= 1'b0;
			probe2_valid_q <= 1'b0;
		end else begin
			probe1_valid_q <= 1'b0;
			probe2_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						probe1_valid_q <= 1'b1;
						last_q <= s_axis_tlast;
						cnt_q <= '0;
						state_q <= S_PASS1;
					end
				end
				S_PASS1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_RECTS - 1)) begin
						state_q <= last_q ? S_LAUNCH : S_IDLE;
					end
				end
				S_LAUNCH: begin
					cnt_q <= '0;
					if (head1.valid) begin
						probe2_valid_q <= 1'b1;
						state_q <= S_PASS2;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_PASS2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_RECTS - 1)) begin
						state_q <= S_LAUNCH;
					end
				end
				S_EMIT: begin
					if (!head2.valid) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			probe1_rect_q <= '{left: s_axis_tdata[15:0], top: s_axis_tdata[31:16],
				width: s_axis_tdata[47:32], height: s_axis_tdata[63:48]};
		end
		if (shift1) begin
			probe2_rect_q <= head1.rect;
		end
	end

	assign probe1 = '{valid: probe1_valid_q, done: 1'b0, rect: probe1_rect_q};
	assign probe2 = '{valid: probe2_valid_q, done: 1'b0, rect: probe2_rect_q};

	rlc_chain u_first (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg1),
		.probe       (probe1),
		.shift_en    (shift1),
		.head        (head1),
		.second_valid(second1)
	);

	rlc_chain u_second (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg2),
		.probe       (probe2),
		.shift_en    (shift2),
		.head        (head2),
		.second_valid(second2)
	);

	assign m_axis_tvalid = (state_q == S_EMIT) && head2.valid;
	assign m_axis_tdata = {head2.rect.height, head2.rect.width, head2.rect.top, head2.rect.left};
	assign m_axis_tlast = !second2;

	`RLC_ASSERT_SAME(a_no_overlap, clk, arst_n, s_axis_tready, !m_axis_tvalid, "input open while emitting")
	`RLC_ASSERT_NEXT(a_last_ends, clk, arst_n, m_fire && m_axis_tlast, !m_axis_tvalid, "result after last")
	`RLC_ASSERT_NEXT(a_probe_launch, clk, arst_n, s_fire, probe1_valid_q, "request not launched")
	`RLC_ASSERT_SAME(a_first_empty, clk, arst_n, state_q == S_EMIT, !second1 && !head1.valid, "first chain not drained")
endmodule
